/* design/shs_pkg.sv */
// SHA-256 stream hasher: shared types, constants and round functions.
// Used by the front end, the word queue, the compression core and the top level.
// No dependencies.
package shs_pkg;

   localparam int unsigned ByteWidth   = 8;
   localparam int unsigned WordWidth   = 32;
   localparam int unsigned IndexWidth  = 3;
   localparam int unsigned DigestWords = 8;
   localparam int unsigned BlockWords  = 16;
   localparam int unsigned RoundCount  = 64;
   localparam int unsigned QueueDepthDefault = 4;

   typedef logic [WordWidth-1:0] word_type;

   // one message word on its way from the front end to the core
   typedef struct packed {
      logic     last;   // final word of the final padded block
      word_type data;
   } qentry_type;

   typedef enum logic {
      ACT_ABSORB = 1'b0,
      ACT_FINISH = 1'b1
   } action_type;

   localparam logic [ByteWidth-1:0] PadByte = 8'h80;
   // word positions inside a block that carry the bit length
   localparam logic [3:0] LenHiWord = 4'd14;
   localparam logic [3:0] LenLoWord = 4'd15;

   localparam word_type RoundK [RoundCount] = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
      32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
      32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
      32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
      32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
      32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
      32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
      32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
      32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
      32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
      32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
   };

   localparam word_type InitH [DigestWords] = '{
      32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
      32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
   };

   function automatic word_type rotr(word_type x, int unsigned n);
      return (x >> n) | (x << (WordWidth - n));
   endfunction

   function automatic word_type big_sigma0(word_type x);
      return rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
   endfunction

   function automatic word_type big_sigma1(word_type x);
      return rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
   endfunction

   function automatic word_type small_sigma0(word_type x);
      return rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
   endfunction

   function automatic word_type small_sigma1(word_type x);
      return rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
   endfunction

   function automatic word_type choose(word_type e, word_type f, word_type g);
      return (e & f) ^ (~e & g);
   endfunction

   function automatic word_type majority(word_type a, word_type b, word_type c);
      return (a & b) ^ (a & c) ^ (b & c);
   endfunction

endpackage

/* design/shs_front.sv */
// Front end: accepts byte items, packs them into 32-bit message words and
// generates the padding and length words on a finish item. Uses shs_pkg.
module shs_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic [7:0]              req_tdata,   // [7:0] data_byte
   input  logic                    req_tuser,   // [0] action
   output logic                    push_valid,
   input  logic                    push_ready,
   output shs_pkg::qentry_type     push_entry
);

   typedef enum logic [1:0] {
      F_IDLE = 2'b01,
      F_PAD  = 2'b10
   } fstate_type;

   fstate_type   state_ff, state_in;
   logic [63:0]  count_ff, count_in;     // message length in bytes, wraps
   logic [23:0]  word_ff, word_in;       // bytes of the partial word
   logic [1:0]   bpos_ff, bpos_in;       // bytes held in the partial word
   logic [3:0]   pos_ff, pos_in;         // word position inside the block
   logic         first_ff, first_in;
   logic         final_ff, final_in;     // this block carries the length
   logic [63:0]  len_ff, len_in;         // message length in bits
   shs_pkg::word_type pad_word;

   // first padded word: partial bytes, then the pad marker, then zeros
   always_comb begin
      case (bpos_ff)
         2'd0:    pad_word = {shs_pkg::PadByte, 24'h0};
         2'd1:    pad_word = {word_ff[7:0], shs_pkg::PadByte, 16'h0};
         2'd2:    pad_word = {word_ff[15:0], shs_pkg::PadByte, 8'h0};
         default: pad_word = {word_ff[23:0], shs_pkg::PadByte};
      endcase
   end

   assign req_tready = (state_ff == F_IDLE) && push_ready;

   // accept bytes, then walk through the padding words
   always_comb begin
      state_in   = state_ff;
      count_in   = count_ff;
      word_in    = word_ff;
      bpos_in    = bpos_ff;
      pos_in     = pos_ff;
      first_in   = first_ff;
      final_in   = final_ff;
      len_in     = len_ff;
      push_valid = 1'b0;
      push_entry = '{last: 1'b0, data: {word_ff, req_tdata}};
      unique case (state_ff)
         F_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (shs_pkg::action_type'(req_tuser) == shs_pkg::ACT_ABSORB) begin
                  word_in  = {word_ff[15:0], req_tdata};
                  count_in = count_ff + 64'd1;
                  if (count_ff[1:0] == 2'b11) begin
                     push_valid = 1'b1;
                  end
               end else begin
                  bpos_in  = count_ff[1:0];
                  pos_in   = count_ff[5:2];
                  first_in = 1'b1;
                  final_in = (count_ff[5:2] < shs_pkg::LenHiWord);
                  len_in   = {count_ff[60:0], 3'b000};
                  count_in = '0;
                  state_in = F_PAD;
               end
            end
         end
         F_PAD: begin
            push_valid      = 1'b1;
            push_entry.last = final_ff && (pos_ff == shs_pkg::LenLoWord);
            if (first_ff) begin
               push_entry.data = pad_word;
            end else if (final_ff && (pos_ff == shs_pkg::LenHiWord)) begin
               push_entry.data = len_ff[63:32];
            end else if (final_ff && (pos_ff == shs_pkg::LenLoWord)) begin
               push_entry.data = len_ff[31:0];
            end else begin
               push_entry.data = '0;
            end
            if (push_ready) begin
               first_in = 1'b0;
               pos_in   = pos_ff + 4'd1;
               if (pos_ff == shs_pkg::LenLoWord) begin
                  final_in = 1'b1;
                  if (final_ff) begin
                     state_in = F_IDLE;
                  end
               end
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      bpos_ff  <= bpos_in;
      pos_ff   <= pos_in;
      first_ff <= first_in;
      final_ff <= final_in;
      len_ff   <= len_in;
   end

endmodule

/* design/shs_queue.sv */
// Short word queue between the front end and the compression core.
// Uses shs_pkg for the entry type.
module shs_queue #(
   parameter int unsigned Depth = shs_pkg::QueueDepthDefault
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  shs_pkg::qentry_type push_entry,
   output logic                pop_valid,
   input  logic                pop_ready,
   output shs_pkg::qentry_type pop_entry
);

   localparam int unsigned PtrWidth   = $clog2(Depth);
   localparam int unsigned CountWidth = $clog2(Depth + 1);

   shs_pkg::qentry_type   slot_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign push_ready = (count_ff != CountWidth'(Depth));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // write one slot
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* design/shs_core.sv */
// Compression core: SHA-256 rounds, one per cycle unless waiting on the queue, over a
// rolling 16-word schedule window, chaining update, and digest word output. Uses shs_pkg.
module shs_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                pop_valid,
   output logic                pop_ready,
   input  shs_pkg::qentry_type pop_entry,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [31:0]         rsp_tdata,   // [31:0] digest_word
   output logic [2:0]          rsp_tuser,   // [2:0] word_index
   output logic                rsp_tlast    // last_word
);

   typedef enum logic [2:0] {
      C_RUN  = 3'b001,
      C_ADD  = 3'b010,
      C_EMIT = 3'b100
   } cstate_type;

   cstate_type        state_ff, state_in;
   logic [5:0]        round_ff, round_in;
   logic [2:0]        idx_ff, idx_in;
   logic              lastblk_ff, lastblk_in;
   shs_pkg::word_type h_ff [shs_pkg::DigestWords];
   shs_pkg::word_type h_in [shs_pkg::DigestWords];
   shs_pkg::word_type v_ff [shs_pkg::DigestWords];
   shs_pkg::word_type v_in [shs_pkg::DigestWords];
   shs_pkg::word_type win_ff [shs_pkg::BlockWords];
   shs_pkg::word_type win_in [shs_pkg::BlockWords];
   shs_pkg::word_type wcur_ff, wcur_in;
   shs_pkg::word_type round_w, t1, t2, w_next;
   logic              loading, step;

   // first sixteen rounds take their word straight from the queue
   assign loading   = (round_ff[5:4] == 2'b00);
   assign pop_ready = (state_ff == C_RUN) && loading;
   assign step      = (state_ff == C_RUN) && (!loading || pop_valid);
   assign round_w   = loading ? pop_entry.data : wcur_ff;

   // round datapath and next schedule word
   assign t1 = v_ff[7] + shs_pkg::big_sigma1(v_ff[4])
             + shs_pkg::choose(v_ff[4], v_ff[5], v_ff[6])
             + shs_pkg::RoundK[round_ff] + round_w;
   assign t2 = shs_pkg::big_sigma0(v_ff[0]) + shs_pkg::majority(v_ff[0], v_ff[1], v_ff[2]);
   assign w_next = shs_pkg::small_sigma1(win_ff[15]) + win_ff[10]
                 + shs_pkg::small_sigma0(win_ff[2]) + win_ff[1];

   assign rsp_tvalid = (state_ff == C_EMIT);
   assign rsp_tdata  = h_ff[idx_ff];
   assign rsp_tuser  = idx_ff;
   assign rsp_tlast  = (idx_ff == 3'(shs_pkg::DigestWords - 1));

   // sequence rounds, chaining add and digest output
   always_comb begin
      state_in   = state_ff;
      round_in   = round_ff;
      idx_in     = idx_ff;
      lastblk_in = lastblk_ff;
      wcur_in    = wcur_ff;
      h_in       = h_ff;
      v_in       = v_ff;
      win_in     = win_ff;
      unique case (state_ff)
         C_RUN: begin
            if (step) begin
               for (int i = 0; i < shs_pkg::BlockWords - 1; i++) begin
                  win_in[i] = win_ff[i+1];
               end
               win_in[shs_pkg::BlockWords-1] = round_w;
               wcur_in = w_next;
               v_in[7] = v_ff[6];
               v_in[6] = v_ff[5];
               v_in[5] = v_ff[4];
               v_in[4] = v_ff[3] + t1;
               v_in[3] = v_ff[2];
               v_in[2] = v_ff[1];
               v_in[1] = v_ff[0];
               v_in[0] = t1 + t2;
               round_in = round_ff + 6'd1;
               if (round_ff == 6'(shs_pkg::BlockWords - 1)) begin
                  lastblk_in = pop_entry.last;
               end
               if (round_ff == 6'(shs_pkg::RoundCount - 1)) begin
                  state_in = C_ADD;
               end
            end
         end
         C_ADD: begin
            for (int i = 0; i < shs_pkg::DigestWords; i++) begin
               h_in[i] = h_ff[i] + v_ff[i];
               v_in[i] = h_ff[i] + v_ff[i];
            end
            idx_in   = '0;
            state_in = lastblk_ff ? C_EMIT : C_RUN;
         end
         C_EMIT: begin
            if (rsp_tready) begin
               idx_in = idx_ff + 3'd1;
               if (rsp_tlast) begin
                  h_in     = shs_pkg::InitH;
                  v_in     = shs_pkg::InitH;
                  state_in = C_RUN;
               end
            end
         end
         default: state_in = C_RUN;
      endcase
   end

   // control and chaining state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= C_RUN;
         round_ff   <= '0;
         idx_ff     <= '0;
         lastblk_ff <= 1'b0;
         h_ff       <= shs_pkg::InitH;
         v_ff       <= shs_pkg::InitH;
      end else begin
         state_ff   <= state_in;
         round_ff   <= round_in;
         idx_ff     <= idx_in;
         lastblk_ff <= lastblk_in;
         h_ff       <= h_in;
         v_ff       <= v_in;
      end
   end

   // schedule window
   always_ff @(posedge clock) begin
      win_ff  <= win_in;
      wcur_ff <= wcur_in;
   end

endmodule

/* design/sha256_stream_hasher_top.sv */
// SHA-256 stream hasher, top level: front end, word queue and compression core.
// Depends on shs_pkg, shs_front, shs_queue and shs_core.
//
//   channel  direction  handshake              tdata               tuser / tlast
//   req      in         req_tvalid/req_tready  [7:0] data_byte     tuser[0] action
//   rsp      out        rsp_tvalid/rsp_tready  [31:0] digest_word  tuser[2:0] word_index,
//                                                                   tlast last_word
//
// An absorb item is accepted while the front end is idle and the queue has room; every
// fourth byte pushes a word into the queue. The core runs one round per cycle when not
// waiting on the queue: 64 rounds plus a chaining add per block. The first 16 rounds
// wait on the incoming bytes, and at the default depth the queue holds only 16 bytes
// over the remaining rounds and the chaining add.
// A finish item starts the padding: the front end pushes the padding words one per
// cycle while the queue has room (one or two blocks), and the core presents eight
// digest words one per cycle while rsp_tready is high.
// Reset is synchronous; there is no clearing pass. Either side may stall: the
// queue lets the front end keep taking bytes while the core computes or emits,
// until the queue fills.
module sha256_stream_hasher_top #(
   parameter int unsigned QueueDepth = shs_pkg::QueueDepthDefault
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic        req_tuser,   // [0] action
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] digest_word
   output logic [2:0]  rsp_tuser,   // [2:0] word_index
   output logic        rsp_tlast    // last_word
);

   logic                push_valid, push_ready;
   logic                pop_valid, pop_ready;
   shs_pkg::qentry_type push_entry, pop_entry;

   shs_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   shs_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   shs_core u_core (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef NO_ASSERTIONS
   // the final digest word ends the burst
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && rsp_tlast) |=> !rsp_tvalid)
      else $error("digest output continued past the last word");

   // digest words come back to back in order
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
         (rsp_tvalid && (rsp_tuser == 3'($past(rsp_tuser) + 3'd1))))
      else $error("digest word index skipped or output dropped");

   // a queue word is never taken while the core is presenting a digest
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !pop_ready)
      else $error("core pulled a message word while emitting a digest");
`endif

endmodule
